// ----- design/drsa_pkg.sv -----
// ----------------------------------------------------------------------------
// drsa_pkg: shared types and constants
// Item structures, status codes and calendar tables for the day-range
// spread accumulator.
// ----------------------------------------------------------------------------
package drsa_pkg;

   localparam int DAY_SLOTS = 65536;
   localparam int BASE_YEAR = 2000;
   localparam int IDX_W     = $clog2(DAY_SLOTS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int DIV_W     = 56;

   // Years from BASE_YEAR on that the calendar logic handles; any later year
   // lies past the last slot of the store.
   localparam int YEAR_SPAN = 256;
   // First century year at or after BASE_YEAR.
   localparam int CENT0     = ((BASE_YEAR + 99) / 100) * 100;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BADDATE = 2'd1;
   localparam logic [1:0] ST_SAT     = 2'd2;

   localparam logic [0:0] KIND_EARN  = 1'b0;
   localparam logic [0:0] KIND_QUERY = 1'b1;

   typedef struct packed {
      logic [0:0]  kind;
      logic [11:0] start_year;
      logic [3:0]  start_month;
      logic [4:0]  start_day;
      logic [11:0] end_year;
      logic [3:0]  end_month;
      logic [4:0]  end_day;
      logic [39:0] amount;
   } req_type;

   typedef struct packed {
      logic [63:0] income;
      logic [1:0]  status;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic conv_start;
      logic conv_end;
      logic div_init;
      logic div_step;
      logic walk_init;
      logic wr_commit;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic bad;
      logic is_query;
      logic walk_last;
   } sts_type;

   // Gregorian leap rule for years within YEAR_SPAN of BASE_YEAR; the few
   // century years in that window are matched against constants.
   function automatic logic is_leap(input logic [11:0] y);
      logic century;
      logic quad;
      begin
         century = 1'b0;
         quad    = 1'b0;
         for (int k = 0; k < 3; k++) begin
            if (y == 12'(CENT0 + 100 * k)) begin
               century = 1'b1;
               quad    = (((CENT0 + 100 * k) % 400) == 0);
            end
         end
         return (y[1:0] == 2'd0) && (!century || quad);
      end
   endfunction

   function automatic logic [8:0] days_before(input logic [3:0] m);
      begin
         case (m)
            4'd1:    return 9'd0;
            4'd2:    return 9'd31;
            4'd3:    return 9'd59;
            4'd4:    return 9'd90;
            4'd5:    return 9'd120;
            4'd6:    return 9'd151;
            4'd7:    return 9'd181;
            4'd8:    return 9'd212;
            4'd9:    return 9'd243;
            4'd10:   return 9'd273;
            4'd11:   return 9'd304;
            default: return 9'd334;
         endcase
      end
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m);
      begin
         case (m) inside
            4'd2:                    return 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            default:                 return 5'd31;
         endcase
      end
   endfunction

   // Days from BASE_YEAR-01-01 to y-01-01, for years within YEAR_SPAN of
   // BASE_YEAR. Leap years before y are the multiples of four counted by a
   // shift, less the century years in the window that are not leap years.
   function automatic logic [20:0] days_from_base(input logic [11:0] y);
      logic [7:0]  q;
      logic [20:0] n;
      begin
         q = 8'(y - 12'(BASE_YEAR));
         n = 21'(21'(q) * 21'd365) + 21'((y - 12'd1) >> 2)
           - 21'((BASE_YEAR - 1) / 4);
         for (int k = 0; k < 3; k++) begin
            if ((((CENT0 + 100 * k) % 400) != 0) && (y > 12'(CENT0 + 100 * k))) begin
               n = n - 21'd1;
            end
         end
         return n;
      end
   endfunction

endpackage

// ----- design/day_range_spread_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// day_range_spread_accumulator_core: per-day amount store with range ops
// Each item goes through conversion of both dates, then, for an earn, the
// bit-serial division of the amount over the days of the range, then a walk
// that reads each day and, for an earn, writes it back; bad dates skip both.
// One item at a time: the next item is taken the cycle after the result.
// After reset a clearing pass zeroes all DAY_SLOTS (65536) slots of the store,
// and no item is accepted until it finishes.
// ----------------------------------------------------------------------------
module day_range_spread_accumulator_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  drsa_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output drsa_pkg::rsp_type    rsp_data
);

   // Commands and status between the sequencer and the datapath.
   drsa_pkg::cmd_type cmd;
   drsa_pkg::sts_type sts;
   logic              clr_active;
   logic [drsa_pkg::IDX_W-1:0] clr_addr;

   // The sequencer owns both handshakes; the result item is held stable in
   // the datapath registers for as long as it waits to be taken.
   drsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .cmd        (cmd),
      .clr_active (clr_active),
      .clr_addr   (clr_addr)
   );

   // The datapath converts dates, divides the amount, and walks the store.
   drsa_datapath u_dp (
      .clock      (clock),
      .req_data   (req_data),
      .cmd        (cmd),
      .clr_active (clr_active),
      .clr_addr   (clr_addr),
      .sts        (sts),
      .result     (rsp_data)
   );

endmodule

// ----- design/drsa_ram.sv -----
// ----------------------------------------------------------------------------
// drsa_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module drsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/drsa_datapath.sv -----
// ----------------------------------------------------------------------------
// drsa_datapath: date conversion, share divider and range walk
// Converts dates one at a time, divides bit-serially, and reads or updates
// the daily store one day at a time, each day in a read then a commit step.
// ----------------------------------------------------------------------------
module drsa_datapath (
   input  logic                 clock,
   input  drsa_pkg::req_type    req_data,
   input  drsa_pkg::cmd_type    cmd,
   input  logic                 clr_active,
   input  logic [drsa_pkg::IDX_W-1:0] clr_addr,
   output drsa_pkg::sts_type    sts,
   output drsa_pkg::rsp_type    result
);

   localparam int IW = drsa_pkg::IDX_W;
   localparam int CW = drsa_pkg::CNT_W;
   localparam int DW = drsa_pkg::DIV_W;

   drsa_pkg::req_type item_ff;
   logic [IW-1:0] first_ff, last_ff, addr_ff;
   logic          bad_ff;
   logic [DW-1:0] quo_ff, rem_ff;
   logic [63:0]   acc_ff;
   logic          sat_ff;
   logic [63:0]   rdata;

   logic [11:0] cy;
   logic [3:0]  cm;
   logic [4:0]  cd;
   logic        leap;
   logic [4:0]  mlen;
   logic [20:0] dn;
   logic        cbad;
   logic [CW-1:0] span;
   logic [DW:0]   rem_sh;
   logic [63:0]   share;
   logic [63:0]   wdata;
   logic          we;
   logic [IW-1:0] ram_addr;

   always_comb begin
      if (cmd.conv_start) begin
         cy = item_ff.start_year; cm = item_ff.start_month; cd = item_ff.start_day;
      end else begin
         cy = item_ff.end_year; cm = item_ff.end_month; cd = item_ff.end_day;
      end
      leap = drsa_pkg::is_leap(cy);
      mlen = drsa_pkg::month_len(cm) + ((cm == 4'd2 && leap) ? 5'd1 : 5'd0);
      dn = drsa_pkg::days_from_base(cy) + 21'(drsa_pkg::days_before(cm))
         + ((cm > 4'd2 && leap) ? 21'd1 : 21'd0) + 21'(cd - 5'd1);
      cbad = (cy < 12'(drsa_pkg::BASE_YEAR))
          || (cy >= 12'(drsa_pkg::BASE_YEAR + drsa_pkg::YEAR_SPAN))
          || (cm < 4'd1) || (cm > 4'd12)
          || (cd < 5'd1) || (cd > mlen) || (dn >= 21'(drsa_pkg::DAY_SLOTS));
   end

   assign span   = CW'(last_ff) - CW'(first_ff) + CW'(1);
   assign rem_sh = {rem_ff, quo_ff[DW-1]};
   assign share  = 64'(quo_ff);

   always_comb begin
      if (rdata > 64'hFFFF_FFFF_FFFF_FFFF - share) begin
         wdata = 64'hFFFF_FFFF_FFFF_FFFF;
      end else begin
         wdata = rdata + share;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
         bad_ff  <= 1'b0;
         acc_ff  <= '0;
         sat_ff  <= 1'b0;
      end
      if (cmd.conv_start) begin
         first_ff <= dn[IW-1:0];
         if (cbad) bad_ff <= 1'b1;
      end
      if (cmd.conv_end) begin
         last_ff <= dn[IW-1:0];
         if (cbad || (dn[IW-1:0] < first_ff)) bad_ff <= 1'b1;
      end
      if (cmd.div_init) begin
         quo_ff <= {item_ff.amount, 16'd0};
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rem_sh >= (DW+1)'(span)) begin
            rem_ff <= DW'(rem_sh - (DW+1)'(span));
            quo_ff <= {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b0};
         end
      end
      if (cmd.walk_init) begin
         addr_ff <= first_ff;
      end
      if (cmd.wr_commit) begin
         if (item_ff.kind == drsa_pkg::KIND_EARN) begin
            if (rdata > 64'hFFFF_FFFF_FFFF_FFFF - share) sat_ff <= 1'b1;
         end else if (acc_ff > 64'hFFFF_FFFF_FFFF_FFFF - rdata) begin
            acc_ff <= 64'hFFFF_FFFF_FFFF_FFFF;
            sat_ff <= 1'b1;
         end else begin
            acc_ff <= acc_ff + rdata;
         end
         addr_ff <= addr_ff + IW'(1);
      end
   end

   assign we = clr_active || (cmd.wr_commit && item_ff.kind == drsa_pkg::KIND_EARN);
   assign ram_addr = clr_active ? clr_addr : addr_ff;

   drsa_ram #(.WIDTH(64), .DEPTH(drsa_pkg::DAY_SLOTS)) u_ram (
      .clock (clock),
      .we    (we),
      .addr  (ram_addr),
      .wdata (clr_active ? 64'd0 : wdata),
      .rdata (rdata)
   );

   assign sts.bad       = bad_ff;
   assign sts.is_query  = (item_ff.kind == drsa_pkg::KIND_QUERY);
   assign sts.walk_last = (addr_ff == last_ff);

   always_comb begin
      if (bad_ff) begin
         result.income = '0;
         result.status = drsa_pkg::ST_BADDATE;
      end else begin
         result.income = (item_ff.kind == drsa_pkg::KIND_QUERY) ? acc_ff : 64'd0;
         result.status = sat_ff ? drsa_pkg::ST_SAT : drsa_pkg::ST_OK;
      end
   end

endmodule

// ----- design/drsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// drsa_ctrl: sequencer for the accumulator
// Runs the clearing pass, then steps each item through conversion,
// division and the range walk, and holds the result until taken.
// ----------------------------------------------------------------------------
module drsa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  drsa_pkg::sts_type    sts,
   output drsa_pkg::cmd_type    cmd,
   output logic                 clr_active,
   output logic [drsa_pkg::IDX_W-1:0] clr_addr
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CONVS = 3'd2;
   localparam logic [2:0] S_CONVE = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_WRITE = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   localparam int DCW = $clog2(drsa_pkg::DIV_W);

   logic [2:0]   state_ff, state_in;
   logic [drsa_pkg::IDX_W-1:0] clr_ff, clr_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      dcnt_in  = dcnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + (drsa_pkg::IDX_W)'(1);
            if (clr_ff == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CONVS;
            end
         end
         S_CONVS: begin
            cmd.conv_start = 1'b1;
            state_in = S_CONVE;
         end
         S_CONVE: begin
            cmd.conv_end = 1'b1;
            cmd.div_init = 1'b1;
            dcnt_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (sts.bad) begin
               state_in = S_DONE;
            end else begin
               cmd.walk_init = (dcnt_ff == '0);
               if (sts.is_query) begin
                  state_in = S_READ;
               end else begin
                  cmd.div_step = 1'b1;
                  dcnt_in = dcnt_ff + DCW'(1);
                  if (dcnt_ff == DCW'(drsa_pkg::DIV_W - 1)) state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.wr_commit = 1'b1;
            state_in = sts.walk_last ? S_DONE : S_READ;
         end
         S_DONE: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_DONE);
   assign clr_active = (state_ff == S_CLEAR);
   assign clr_addr   = clr_ff;

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the day-range spread accumulator
// Drives earn and query items over calendar ranges, keeps its own copy of the
// per-day store to work out each expected result, and compares every result
// field by field. Covers calendar edge cases, whole-store ranges, back
// pressure and a random mix of good and broken items.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import drsa_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Bench copy of the store, the queue of expected results, error count.
   logic [63:0] day_total [0:DAY_SLOTS-1];
   rsp_type     pending_rsp [$];
   int          mismatches;
   int          burst_left;
   int          stall_mode;
   int          hold_left;

   day_range_spread_accumulator_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: covers the clearing pass, the whole-store walks and the rest.
   initial begin
      #50_000_000;
      $display("simulation failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Calendar helpers. Day numbers count from BASE_YEAR-01-01.
   // ------------------------------------------------------------------------
   function automatic bit leap_year(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned days_to_year(input int unsigned y);
      int unsigned p;
      p = y - 1;
      return 365 * p + p / 4 - p / 100 + p / 400;
   endfunction

   function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
      case (m)
         2:           return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   // Converts a date to a store slot; returns 0 when the date is invalid or
   // falls past the last slot.
   function automatic bit date_to_slot(input logic [11:0] y, input logic [3:0] m,
                                       input logic [4:0] d, output int unsigned slot);
      int unsigned dn;
      int unsigned mm;
      slot = 0;
      if (y < BASE_YEAR || m < 1 || m > 12 || d < 1) return 1'b0;
      if (d > days_in_month(y, m)) return 1'b0;
      dn = days_to_year(y) - days_to_year(BASE_YEAR);
      for (mm = 1; mm < m; mm++) dn += days_in_month(y, mm);
      dn += d - 1;
      if (dn >= DAY_SLOTS) return 1'b0;
      slot = dn;
      return 1'b1;
   endfunction

   task automatic slot_to_date(input int unsigned slot, output logic [11:0] y,
                               output logic [3:0] m, output logic [4:0] d);
      int unsigned rest;
      int unsigned yy;
      int unsigned mm;
      rest = slot;
      yy = BASE_YEAR;
      while (rest >= (leap_year(yy) ? 366 : 365)) begin
         rest -= leap_year(yy) ? 366 : 365;
         yy++;
      end
      mm = 1;
      while (rest >= days_in_month(yy, mm)) begin
         rest -= days_in_month(yy, mm);
         mm++;
      end
      y = 12'(yy);
      m = 4'(mm);
      d = 5'(rest + 1);
   endtask

   // Builds a well-formed item over the slot range first..last.
   task automatic range_item(input logic [0:0] kind, input int unsigned first,
                             input int unsigned last, input logic [39:0] amt,
                             output req_type it);
      it = '0;
      it.kind = kind;
      it.amount = amt;
      slot_to_date(first, it.start_year, it.start_month, it.start_day);
      slot_to_date(last, it.end_year, it.end_month, it.end_day);
   endtask

   function automatic logic [39:0] rand_amount();
      return {8'($urandom_range(255, 0)), $urandom()};
   endfunction

   // ------------------------------------------------------------------------
   // Predictor: applies one item to the bench store and gives its result.
   // ------------------------------------------------------------------------
   function automatic rsp_type apply_item(input req_type it);
      rsp_type     r;
      int unsigned first;
      int unsigned last;
      logic [63:0] share;
      bit          ok_a;
      bit          ok_b;
      r.income = '0;
      r.status = ST_OK;
      ok_a = date_to_slot(it.start_year, it.start_month, it.start_day, first);
      ok_b = date_to_slot(it.end_year, it.end_month, it.end_day, last);
      if (!ok_a || !ok_b || first > last) begin
         r.status = ST_BADDATE;
         return r;
      end
      if (it.kind == KIND_EARN) begin
         share = ({24'd0, it.amount} << 16) / (64'(last - first) + 64'd1);
         for (int unsigned i = first; i <= last; i++) begin
            if (day_total[i] > ~share) begin
               day_total[i] = '1;
               r.status = ST_SAT;
            end else begin
               day_total[i] = day_total[i] + share;
            end
         end
      end else begin
         for (int unsigned i = first; i <= last; i++) begin
            if (r.income > ~day_total[i]) begin
               r.income = '1;
               r.status = ST_SAT;
            end else begin
               r.income = r.income + day_total[i];
            end
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Sender: bursts of random length with random gaps. Each accepted item is
   // predicted at the edge where it is taken.
   // ------------------------------------------------------------------------
   task automatic send_item(input req_type it);
      int gap;
      if (burst_left <= 0) begin
         gap = $urandom_range(6, 0);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(12, 1);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(apply_item(it));
      burst_left--;
   endtask

   // The sender pauses until every expected result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: stalls on its own pattern, plus a long hold when a test asks.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(3, 0) == 0);
            default: rsp_stall <= 1'($urandom_range(1, 0));
         endcase
      end
   end

   // Result checker: each accepted result against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: income=%h status=%0d",
                        rsp_data.income, rsp_data.status);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.income !== want.income || rsp_data.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected income=%h status=%0d, got income=%h status=%0d",
                           want.income, want.status, rsp_data.income, rsp_data.status);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Calendar edges: leap days, bad months and days, first and last slot.
   task automatic test_calendar_edges();
      req_type it;
      stall_mode = 1;
      range_item(KIND_EARN, 0, 0, '1, it);
      send_item(it);
      range_item(KIND_EARN, DAY_SLOTS - 1, DAY_SLOTS - 1, '0, it);
      send_item(it);
      range_item(KIND_EARN, DAY_SLOTS - 1, DAY_SLOTS - 1, 40'd12345, it);
      send_item(it);
      range_item(KIND_QUERY, 0, 0, '0, it);
      send_item(it);
      range_item(KIND_QUERY, DAY_SLOTS - 2, DAY_SLOTS - 1, '0, it);
      send_item(it);
      // Leap day of 2000 and 2004 are real, 2100 is not a leap year.
      it = '{KIND_EARN, 12'd2000, 4'd2, 5'd29, 12'd2004, 4'd2, 5'd29, 40'd999};
      send_item(it);
      it = '{KIND_QUERY, 12'd2000, 4'd2, 5'd28, 12'd2000, 4'd3, 5'd1, 40'd0};
      send_item(it);
      it = '{KIND_EARN, 12'd2100, 4'd2, 5'd29, 12'd2100, 4'd3, 5'd1, 40'd5};
      send_item(it);
      // Month zero, month thirteen, day zero, April 31, year before the base.
      it = '{KIND_QUERY, 12'd2001, 4'd0, 5'd1, 12'd2001, 4'd2, 5'd1, 40'd0};
      send_item(it);
      it = '{KIND_EARN, 12'd2001, 4'd1, 5'd1, 12'd2001, 4'd13, 5'd1, 40'd7};
      send_item(it);
      it = '{KIND_QUERY, 12'd2001, 4'd1, 5'd0, 12'd2001, 4'd2, 5'd1, 40'd0};
      send_item(it);
      it = '{KIND_EARN, 12'd2003, 4'd4, 5'd31, 12'd2003, 4'd5, 5'd2, 40'd7};
      send_item(it);
      it = '{KIND_QUERY, 12'd1999, 4'd12, 5'd31, 12'd2000, 4'd1, 5'd2, 40'd0};
      send_item(it);
      // A date that converts fine but lies past the last slot.
      it = '{KIND_EARN, 12'd2179, 4'd12, 5'd31, 12'd2179, 4'd12, 5'd31, 40'd7};
      send_item(it);
      // Reversed range.
      range_item(KIND_QUERY, 100, 99, '0, it);
      send_item(it);
      range_item(KIND_EARN, 500, 10, 40'd77, it);
      send_item(it);
      // Uneven division that drops a remainder.
      range_item(KIND_EARN, 10, 16, 40'd1000003, it);
      send_item(it);
      range_item(KIND_QUERY, 9, 17, '0, it);
      send_item(it);
      wait_drained();
   endtask

   // Whole-store earn and query: the longest walks the block can make.
   task automatic test_full_range();
      req_type it;
      stall_mode = 0;
      range_item(KIND_EARN, 0, DAY_SLOTS - 1, '1, it);
      send_item(it);
      range_item(KIND_QUERY, 0, DAY_SLOTS - 1, '0, it);
      send_item(it);
      wait_drained();
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering.
   task automatic test_backpressure();
      req_type it;
      stall_mode = 0;
      hold_left = 3000;
      burst_left = 100;
      for (int n = 0; n < 8; n++) begin
         range_item(n[0] ? KIND_QUERY : KIND_EARN, 40 + n, 45 + n, rand_amount(), it);
         send_item(it);
      end
      wait_drained();
   endtask

   // Random mix: mostly well-formed ranges near a busy region, some broken.
   task automatic test_random();
      req_type     it;
      int unsigned first;
      int unsigned span;
      int          pick;
      logic [95:0] raw;
      for (int n = 0; n < 70; n++) begin
         if (n % 25 == 0) stall_mode = $urandom_range(2, 0);
         pick = $urandom_range(19, 0);
         if (pick < 14) begin
            span  = ($urandom_range(9, 0) == 0) ? $urandom_range(800, 0)
                                                : $urandom_range(30, 0);
            first = ($urandom_range(3, 0) == 0) ? $urandom_range(DAY_SLOTS - 1 - span, 0)
                                                : $urandom_range(400, 0);
            range_item(1'($urandom_range(1, 0)), first, first + span, rand_amount(), it);
         end else if (pick < 17) begin
            first = $urandom_range(400, 1);
            range_item(1'($urandom_range(1, 0)), first, first - $urandom_range(first, 1),
                       rand_amount(), it);
         end else begin
            raw = {$urandom(), $urandom(), $urandom()};
            it = raw[$bits(req_type)-1:0];
            it.amount = rand_amount();
         end
         send_item(it);
      end
      wait_drained();
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_stall  = 1'b0;
      mismatches = 0;
      burst_left = 0;
      stall_mode = 0;
      hold_left  = 0;
      for (int i = 0; i < DAY_SLOTS; i++) day_total[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_calendar_edges();
      test_full_range();
      test_backpressure();
      test_random();

      // Let any stray result show up before the verdict.
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
